FILE: rtl/vsr_pkg.sv
// ----------------------------------------------------------------------------
// vsr_pkg: shared types and constants of the versioned stack
// Command codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package vsr_pkg;

	// default sizes
	localparam int unsigned DEF_MAX_OPS    = 1024;
	localparam int unsigned DEF_VALUE_BITS = 32;

	// fixed field widths of the command beat
	localparam int unsigned CMD_BITS  = 2;
	localparam int unsigned BACK_BITS = 10;
	localparam int unsigned OUT_BITS  = 32;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_PUSH   = 2'd0,
		CMD_POP    = 2'd1,
		CMD_REVERT = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_READ = 1'b1
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/vsr_ram.sv
// ----------------------------------------------------------------------------
// vsr_ram: simple dual-port synchronous memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vsr_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/versioned_stack_with_rollback.sv
// ----------------------------------------------------------------------------
// versioned_stack_with_rollback: persistent stack with revert by k operations
// Versions live in a node memory (parent link and value below each node) and
// a history memory (top pointer and top value before each operation).
// ----------------------------------------------------------------------------
// A command is accepted in S_IDLE and its memory read is in flight in S_READ;
//   done and the result beat are registered as the sequencer leaves S_READ.
// Busy is high in S_READ, while the node or history memory read is in flight,
//   so a new command is taken only once the sequencer is back in S_IDLE.
// Reset sets the top pointer to null and clears the operation and node counts
//   and the strobe; the memories are not cleared and need no clearing pass.
// The receiver cannot stall: done is high for exactly one cycle per command.
`default_nettype none

module versioned_stack_with_rollback
	import vsr_pkg::*;
#(
	parameter int unsigned MAX_OPS    = DEF_MAX_OPS,
	parameter int unsigned VALUE_BITS = DEF_VALUE_BITS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output      logic                        busy,
	input  wire logic [CMD_BITS-1:0]         command,
	input  wire logic signed [OUT_BITS-1:0]  push_value,
	input  wire logic [BACK_BITS-1:0]        back_count,
	output      logic                        done,
	output      logic signed [OUT_BITS-1:0]  top_value,
	output      logic                        is_empty,
	output      logic                        overflow
);

	localparam int unsigned AW = $clog2(MAX_OPS);
	localparam int unsigned PW = $clog2(MAX_OPS + 1);
	localparam int unsigned CW = (PW > BACK_BITS) ? PW : BACK_BITS;
	localparam int unsigned EW = PW + VALUE_BITS;
	localparam logic [PW-1:0] NULL_PTR = PW'(MAX_OPS);
	localparam logic [PW-1:0] MAX_CNT  = PW'(MAX_OPS);

	state_t state_q, state_d;

	logic [PW-1:0]         top_q;
	logic [VALUE_BITS-1:0] top_val_q;
	logic [PW-1:0]         op_count_q;
	logic [PW-1:0]         node_count_q;

	cmd_t cmd_s1;
	logic ovf_s1;
	logic pop_ok_s1;
	logic rev_keep_s1;
	logic rev_null_s1;

	logic accept;
	logic hist_full;
	cmd_t cmd_in;
	logic rev_null;
	logic rev_keep;
	logic [CW-1:0] rev_diff;
	logic [VALUE_BITS-1:0] push_trunc;
	logic signed [63:0] push_wide;

	logic [EW-1:0] node_wdata, node_rdata;
	logic [EW-1:0] hist_wdata, hist_rdata;
	logic node_we, node_re, hist_we, hist_re;

	logic [PW-1:0]         nxt_top;
	logic [VALUE_BITS-1:0] nxt_val;
	logic signed [63:0]    nxt_wide;

	// decode the incoming command beat
	always_comb begin
		cmd_in     = cmd_t'(command);
		accept     = start && !busy;
		hist_full  = (op_count_q >= MAX_CNT);
		rev_null   = (CW'(back_count) > CW'(op_count_q));
		rev_keep   = (back_count == '0);
		rev_diff   = CW'(op_count_q) - CW'(back_count);
		push_wide  = 64'(push_value);
		push_trunc = push_wide[VALUE_BITS-1:0];
	end

	// memory port control
	always_comb begin
		hist_we    = accept && !hist_full;
		hist_wdata = {top_q, top_val_q};
		hist_re    = hist_we && (cmd_in == CMD_REVERT) && !rev_null && !rev_keep;
		node_we    = hist_we && (cmd_in == CMD_PUSH) && (node_count_q < MAX_CNT);
		node_wdata = {top_q, top_val_q};
		node_re    = hist_we && (cmd_in == CMD_POP) && (top_q != NULL_PTR);
	end

	vsr_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_OPS)
	) u_node_ram (
		.clk  (clk),
		.we   (node_we),
		.waddr(node_count_q[AW-1:0]),
		.wdata(node_wdata),
		.re   (node_re),
		.raddr(top_q[AW-1:0]),
		.rdata(node_rdata)
	);

	vsr_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_OPS)
	) u_hist_ram (
		.clk  (clk),
		.we   (hist_we),
		.waddr(op_count_q[AW-1:0]),
		.wdata(hist_wdata),
		.re   (hist_re),
		.raddr(rev_diff[AW-1:0]),
		.rdata(hist_rdata)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and busy
	always_comb begin
		state_d = state_q;
		busy    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				busy    = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// capture the command for the read stage
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= cmd_in;
			ovf_s1      <= hist_full;
			pop_ok_s1   <= (top_q != NULL_PTR);
			rev_keep_s1 <= rev_keep;
			rev_null_s1 <= rev_null;
		end
	end

	// select the new top from the memory read
	always_comb begin
		nxt_top = top_q;
		nxt_val = top_val_q;
		if (!ovf_s1) begin
			case (cmd_s1)
				CMD_POP: begin
					if (pop_ok_s1) begin
						nxt_top = node_rdata[EW-1 -: PW];
						nxt_val = node_rdata[VALUE_BITS-1:0];
					end
				end
				CMD_REVERT: begin
					if (rev_null_s1) begin
						nxt_top = NULL_PTR;
					end else if (!rev_keep_s1) begin
						nxt_top = hist_rdata[EW-1 -: PW];
						nxt_val = hist_rdata[VALUE_BITS-1:0];
					end
				end
				default: begin
				end
			endcase
		end
		nxt_wide = 64'(signed'(nxt_val));
	end

	// advance pointers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q        <= NULL_PTR;
			op_count_q   <= '0;
			node_count_q <= '0;
		end else if (accept) begin
			if (!hist_full) begin
				op_count_q <= op_count_q + PW'(1);
				if (cmd_in == CMD_PUSH && node_count_q < MAX_CNT) begin
					top_q        <= node_count_q;
					node_count_q <= node_count_q + PW'(1);
				end
			end
		end else if (state_q == S_READ) begin
			top_q <= nxt_top;
		end
	end

	// top value travels with the pointer
	always_ff @(posedge clk) begin
		if (accept) begin
			if (!hist_full && cmd_in == CMD_PUSH && node_count_q < MAX_CNT) begin
				top_val_q <= push_trunc;
			end
		end else if (state_q == S_READ) begin
			top_val_q <= nxt_val;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= (state_q == S_READ);
		end
	end

	// result beat
	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			is_empty  <= (nxt_top == NULL_PTR);
			overflow  <= ovf_s1;
			top_value <= (nxt_top == NULL_PTR) ? -32'sd1 : nxt_wide[OUT_BITS-1:0];
		end
	end

`ifndef SYNTHESIS
	a_done_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_READ))
		else $error("result strobe without a preceding read cycle");

	a_op_bound: assert property (@(posedge clk) disable iff (!arst_n)
		op_count_q <= MAX_CNT && node_count_q <= op_count_q)
		else $error("operation or node count out of range");

	a_top_allocated: assert property (@(posedge clk) disable iff (!arst_n)
		top_q == NULL_PTR || top_q < node_count_q)
		else $error("top pointer names an unallocated node");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow) |-> op_count_q == MAX_CNT)
		else $error("overflow flagged with history not full");
`endif

endmodule

`default_nettype wire

FILE: tb/vsr_stack_tracker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vsr_stack_tracker: shadow of the versioned stack and result comparison
// Watches the command and result beats. Each accepted command is replayed on
// a shadow node table and history, and the top it leaves is queued. Each
// result beat is compared field by field with the oldest queued top.
// ----------------------------------------------------------------------------

module vsr_stack_tracker
	import vsr_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic                        busy,
	input  wire logic [CMD_BITS-1:0]         command,
	input  wire logic signed [OUT_BITS-1:0]  push_value,
	input  wire logic [BACK_BITS-1:0]        back_count,
	input  wire logic                        done,
	input  wire logic signed [OUT_BITS-1:0]  top_value,
	input  wire logic                        is_empty,
	input  wire logic                        overflow,
	output int                               errors,
	output int                               waiting
);

	localparam int unsigned PTR_BITS = $clog2(DEF_MAX_OPS) + 1;
	localparam logic [PTR_BITS-1:0] NULL_PTR = PTR_BITS'(DEF_MAX_OPS);

	typedef struct packed {
		logic signed [OUT_BITS-1:0] top;
		logic                       empty;
		logic                       refused;
	} stack_view_t;

	// shadow versions: node values, links to the node below, top before each op
	logic signed [OUT_BITS-1:0] node_val [DEF_MAX_OPS];
	logic [PTR_BITS-1:0]        node_below [DEF_MAX_OPS];
	logic [PTR_BITS-1:0]        top_before [DEF_MAX_OPS];
	logic [PTR_BITS-1:0]        top_ptr = NULL_PTR;
	int unsigned                ops_done = 0;
	int unsigned                nodes_used = 0;

	stack_view_t expected_tops [$];
	stack_view_t oldest;
	int          fail_count = 0;

	// apply one command to the shadow stack and queue the top it leaves
	task automatic apply_stack_op(cmd_t cmd, logic signed [OUT_BITS-1:0] val,
			logic [BACK_BITS-1:0] back);
		stack_view_t view;
		int unsigned idx;
		view.refused = (ops_done >= DEF_MAX_OPS);
		if (!view.refused) begin
			idx = ops_done;
			top_before[idx] = top_ptr;
			case (cmd)
				CMD_PUSH: begin
					if (nodes_used < DEF_MAX_OPS) begin
						node_val[nodes_used]   = val;
						node_below[nodes_used] = top_ptr;
						top_ptr                = PTR_BITS'(nodes_used);
						nodes_used++;
					end
				end
				CMD_POP: begin
					if (top_ptr != NULL_PTR)
						top_ptr = node_below[top_ptr];
				end
				CMD_REVERT: begin
					// going back past the first op empties the stack
					if (back > idx)
						top_ptr = NULL_PTR;
					else
						top_ptr = top_before[idx - back];
				end
				default: begin
					// no-op: only recorded in the history
				end
			endcase
			ops_done = idx + 1;
		end
		if (top_ptr != NULL_PTR) begin
			view.top   = node_val[top_ptr];
			view.empty = 1'b0;
		end else begin
			view.top   = -1;
			view.empty = 1'b1;
		end
		expected_tops.push_back(view);
	endtask

	// compare result beats, then track newly accepted command beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_ptr    = NULL_PTR;
			ops_done   = 0;
			nodes_used = 0;
			expected_tops.delete();
			errors  <= fail_count;
			waiting <= 0;
		end else begin
			if (done) begin
				if (expected_tops.size() == 0) begin
					$display("%0t: result beat with nothing expected: top %0d empty %0b overflow %0b",
						$time, top_value, is_empty, overflow);
					fail_count++;
				end else begin
					oldest = expected_tops.pop_front();
					if (top_value !== oldest.top) begin
						$display("%0t: top_value mismatch: expected %0d, actual %0d",
							$time, oldest.top, top_value);
						fail_count++;
					end
					if (is_empty !== oldest.empty) begin
						$display("%0t: is_empty mismatch: expected %0b, actual %0b",
							$time, oldest.empty, is_empty);
						fail_count++;
					end
					if (overflow !== oldest.refused) begin
						$display("%0t: overflow mismatch: expected %0b, actual %0b",
							$time, oldest.refused, overflow);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				apply_stack_op(cmd_t'(command), push_value, back_count);
			errors  <= fail_count;
			waiting <= expected_tops.size();
		end
	end

endmodule

FILE: tb/versioned_stack_with_rollback_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// versioned_stack_with_rollback_tb: stimulus and verdict for the versioned stack
// Drives a directed set of corner commands, then bursts of random push, pop,
// revert and no-op beats until the history fills, then a long run of refused
// beats. The stack tracker beside the block predicts and checks every result.
// ----------------------------------------------------------------------------

module versioned_stack_with_rollback_tb;
	import vsr_pkg::*;

	localparam int unsigned IDLE_LIMIT     = 2000;
	localparam int unsigned OVERFLOW_ITEMS = 720;
	localparam int unsigned REVERT_REACH   = 24;

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic [CMD_BITS-1:0]         command;
	logic signed [OUT_BITS-1:0]  push_value;
	logic [BACK_BITS-1:0]        back_count;
	logic                        done;
	logic signed [OUT_BITS-1:0]  top_value;
	logic                        is_empty;
	logic                        overflow;
	int                          errors;
	int                          waiting;
	int unsigned                 ops_sent = 0;
	int unsigned                 idle_cycles = 0;

	versioned_stack_with_rollback uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.push_value (push_value),
		.back_count (back_count),
		.done       (done),
		.top_value  (top_value),
		.is_empty   (is_empty),
		.overflow   (overflow)
	);

	vsr_stack_tracker stack_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.push_value (push_value),
		.back_count (back_count),
		.done       (done),
		.top_value  (top_value),
		.is_empty   (is_empty),
		.overflow   (overflow),
		.errors     (errors),
		.waiting    (waiting)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// present one command beat and hold it until accepted
	task automatic issue(cmd_t cmd, logic signed [OUT_BITS-1:0] val,
			logic [BACK_BITS-1:0] back);
		command    <= cmd;
		push_value <= val;
		back_count <= back;
		start      <= 1'b1;
		do @(posedge clk); while (busy);
		ops_sent++;
	endtask

	// drop start and wait; n, at least one, sets the length of the gap
	task automatic pause(int unsigned n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// hold off until every predicted result has come back
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (waiting != 0);
	endtask

	// random command; reverts mostly go back to recent versions
	task automatic random_op();
		int unsigned pick;
		int unsigned reach;
		cmd_t cmd;
		logic signed [OUT_BITS-1:0] val;
		logic [BACK_BITS-1:0] back;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			cmd = CMD_PUSH;
		else if (pick < 65)
			cmd = CMD_POP;
		else if (pick < 90)
			cmd = CMD_REVERT;
		else
			cmd = CMD_NOP;
		val = $urandom;
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0: val = 32'sh7FFFFFFF;
				1: val = 32'sh80000000;
				2: val = -32'sd1;
				default: val = 32'sd0;
			endcase
		end
		reach = (ops_sent < REVERT_REACH) ? ops_sent + 1 : REVERT_REACH;
		if ($urandom_range(0, 9) == 0)
			back = BACK_BITS'($urandom);
		else
			back = BACK_BITS'($urandom_range(0, reach));
		issue(cmd, val, back);
	endtask

	// stop the run when no beat moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("** versioned_stack_with_rollback: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n     <= 1'b0;
		start      <= 1'b0;
		command    <= CMD_NOP;
		push_value <= '0;
		back_count <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners on the empty stack
		issue(CMD_POP, 32'sd0, '0);
		issue(CMD_REVERT, 32'sd0, '0);
		issue(CMD_REVERT, 32'sd0, '1);
		// extreme values, including a pushed -1 on a non-empty stack
		issue(CMD_PUSH, 32'sh7FFFFFFF, '0);
		issue(CMD_PUSH, 32'sh80000000, '1);
		issue(CMD_PUSH, -32'sd1, 10'h155);
		issue(CMD_PUSH, 32'sd0, 10'h2AA);
		issue(CMD_NOP, '1, '1);
		issue(CMD_REVERT, 32'sd0, '0);
		issue(CMD_POP, 32'sh55555555, '0);
		issue(CMD_POP, 32'sd0, '0);
		issue(CMD_REVERT, 32'sd0, 10'd3);
		issue(CMD_REVERT, 32'sd0, 10'd1);
		// back to exactly the first op, then just past it, then undo both
		issue(CMD_REVERT, 32'sd0, BACK_BITS'(ops_sent));
		issue(CMD_REVERT, 32'sd0, BACK_BITS'(ops_sent + 1));
		issue(CMD_REVERT, 32'sd0, 10'd2);
		issue(CMD_PUSH, 32'sh55555555, '0);
		issue(CMD_PUSH, 32'shAAAAAAAA, '0);
		issue(CMD_POP, 32'sh12345678, '1);
		repeat (6) issue(CMD_POP, 32'sd0, '0);
		issue(CMD_POP, 32'sd0, '0);
		drain_results();

		// random bursts until the history is full and many beats beyond
		while (ops_sent < DEF_MAX_OPS + OVERFLOW_ITEMS) begin
			repeat ($urandom_range(1, 16)) random_op();
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					// no gap: run straight into the next burst
				end
				9: drain_results();
				default: pause($urandom_range(1, 6));
			endcase
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("** versioned_stack_with_rollback: PASSED **");
		else
			$display("** versioned_stack_with_rollback: FAILED **");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/vsr_pkg.sv
rtl/vsr_ram.sv
rtl/versioned_stack_with_rollback.sv
tb/vsr_stack_tracker.sv
tb/versioned_stack_with_rollback_tb.sv
